// ----- src/tksk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksk_pkg
// Shared types and constants of the top-k score keeper.
// ----------------------------------------------------------------------------
package tksk_pkg;

  localparam int POS_W      = 31;
  localparam int TAG_W      = 31;
  localparam int MODE_W     = 2;
  localparam int KEEP_W     = 5;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  // register index as decoded from paddr[2]
  localparam logic KEEP_COUNT_IDX = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic insert;
    logic clear;
    logic rd_start;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic at_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/tksk_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksk channel interfaces
// Input command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tksk_in_if import tksk_pkg::*; #(
  parameter int SCORE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [MODE_W-1:0]             mode;
  logic signed [SCORE_WIDTH-1:0] score;
  logic [POS_W-1:0]              position;
  logic [TAG_W-1:0]              tag;

  modport source (output valid, mode, score, position, tag, input ready);
  modport sink   (input valid, mode, score, position, tag, output ready);
endinterface

interface tksk_out_if import tksk_pkg::*; #(
  parameter int SCORE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SCORE_WIDTH-1:0] out_score;
  logic [POS_W-1:0]              out_position;
  logic [TAG_W-1:0]              out_tag;
  logic                          entry_valid;
  logic                          last;

  modport source (output valid, out_score, out_position, out_tag, entry_valid, last,
                  input ready);
  modport sink   (input valid, out_score, out_position, out_tag, entry_valid, last,
                  output ready);
endinterface

// ----- src/tksk_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksk_ctrl
// Sequencer: takes commands, steps the datapath through a read-out run.
// ----------------------------------------------------------------------------
module tksk_ctrl import tksk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  dp_status_t        st,
  output dp_cmd_t           cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (mode_t'(in_mode))
            MODE_INSERT: cmd.insert = 1'b1;
            MODE_CLEAR:  cmd.clear  = 1'b1;
            MODE_READ: begin
              cmd.rd_start = 1'b1;
              state_next   = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // one item per cycle while the output register can take it
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.empty || st.at_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- src/tksk_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tksk_dp
// Sorted register chain of entries, read-out index and output register.
// ----------------------------------------------------------------------------
module tksk_dp import tksk_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int SCORE_WIDTH = 32,
  parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dp_cmd_t                       cmd,
  output dp_status_t                    st,
  input  logic [CNT_W-1:0]              limit,
  input  logic signed [SCORE_WIDTH-1:0] score,
  input  logic [POS_W-1:0]              position,
  input  logic [TAG_W-1:0]              tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SCORE_WIDTH-1:0] out_score,
  output logic [POS_W-1:0]              out_position,
  output logic [TAG_W-1:0]              out_tag,
  output logic                          out_entry_valid,
  output logic                          out_last
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic signed [SCORE_WIDTH-1:0] ent_score [MAX_ENTRIES];
  logic [POS_W-1:0]              ent_pos   [MAX_ENTRIES];
  logic [TAG_W-1:0]              ent_tag   [MAX_ENTRIES];
  logic [CNT_W-1:0]              count;
  logic [IDX_W-1:0]              rd_idx;

  logic [MAX_ENTRIES-1:0] le;
  logic                   full;
  logic                   beats_min;
  logic                   do_ins;
  logic                   empty;
  logic                   at_last;
  logic                   out_free;

  // le marks stored entries whose score is not above the new one: a prefix
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      le[i] = (CNT_W'(i) < count) && (ent_score[i] <= score);
    end
  end

  assign full      = (count >= limit);
  assign beats_min = (count != '0) && (ent_score[0] < score);
  assign do_ins    = cmd.insert && (!full || beats_min);

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    localparam int PREV = (g == 0) ? 0 : g - 1;
    localparam int NEXT = (g == MAX_ENTRIES - 1) ? g : g + 1;
    logic le_prev;
    logic le_next;
    assign le_prev = (g == 0) ? 1'b1 : le[PREV];
    assign le_next = (g == MAX_ENTRIES - 1) ? 1'b0 : le[NEXT];

    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (!full) begin
          // open a slot after all equal-or-lower scores, shift the rest up
          if (le[g]) begin
            ent_score[g] <= ent_score[g];
            ent_pos[g]   <= ent_pos[g];
            ent_tag[g]   <= ent_tag[g];
          end else if (le_prev) begin
            ent_score[g] <= score;
            ent_pos[g]   <= position;
            ent_tag[g]   <= tag;
          end else begin
            ent_score[g] <= ent_score[PREV];
            ent_pos[g]   <= ent_pos[PREV];
            ent_tag[g]   <= ent_tag[PREV];
          end
        end else begin
          // evict the head: lower entries shift down, new one fills the gap
          if (le_next) begin
            ent_score[g] <= ent_score[NEXT];
            ent_pos[g]   <= ent_pos[NEXT];
            ent_tag[g]   <= ent_tag[NEXT];
          end else if (le_prev && (g == 0 || le[g])) begin
            ent_score[g] <= score;
            ent_pos[g]   <= position;
            ent_tag[g]   <= tag;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (do_ins && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.rd_start) begin
      rd_idx <= '0;
    end else if (cmd.emit) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  assign empty    = (count == '0);
  assign at_last  = ((CNT_W'(rd_idx) + CNT_W'(1)) == count);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (empty) begin
        out_score       <= '0;
        out_position    <= '0;
        out_tag         <= '0;
        out_entry_valid <= 1'b0;
        out_last        <= 1'b1;
      end else begin
        out_score       <= ent_score[rd_idx];
        out_position    <= ent_pos[rd_idx];
        out_tag         <= ent_tag[rd_idx];
        out_entry_valid <= 1'b1;
        out_last        <= at_last;
      end
    end
  end

  assign st.empty    = empty;
  assign st.at_last  = at_last;
  assign st.out_free = out_free;

endmodule

// ----- src/top_k_score_keeper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_score_keeper
// Bounded store of the highest-scoring entries, kept in ascending order.
// ----------------------------------------------------------------------------
//  port     dir   role
//  in_ch    sink  command transfer: insert, read out, clear
//  out_ch   src   one transfer per emitted entry, last marks end of run
//  apb      sink  keep_count register at byte address 0
//
//  insert and clear: the sorted register chain updates in place
//  a read-out emits one transfer per stored entry (one for an empty store),
//  paced by the single output register; no command is taken during it
//  reset clears the entry count and loads keep_count with 16
//  a stalled output holds the run without losing items
// ----------------------------------------------------------------------------
module top_k_score_keeper import tksk_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int SCORE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  tksk_in_if.sink           in_ch,
  tksk_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int LIM_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

  logic [KEEP_W-1:0] keep_count;
  logic [LIM_W-1:0]  kc_wide;
  logic [LIM_W-1:0]  lim_wide;
  logic [CNT_W-1:0]  limit;
  dp_cmd_t           cmd;
  dp_status_t        st;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == KEEP_COUNT_IDX)) begin
      keep_count <= pwdata[KEEP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == KEEP_COUNT_IDX) ? DATA_W'(keep_count) : '0;

  // zero counts as one, above the store depth saturates
  always_comb begin
    kc_wide = LIM_W'(keep_count);
    if (kc_wide == '0) begin
      lim_wide = LIM_W'(1);
    end else if (kc_wide > LIM_W'(MAX_ENTRIES)) begin
      lim_wide = LIM_W'(MAX_ENTRIES);
    end else begin
      lim_wide = kc_wide;
    end
  end

  assign limit = CNT_W'(lim_wide);

  tksk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_mode  (in_ch.mode),
    .st       (st),
    .cmd      (cmd)
  );

  tksk_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SCORE_WIDTH (SCORE_WIDTH),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .limit           (limit),
    .score           (in_ch.score),
    .position        (in_ch.position),
    .tag             (in_ch.tag),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_score       (out_ch.out_score),
    .out_position    (out_ch.out_position),
    .out_tag         (out_ch.out_tag),
    .out_entry_valid (out_ch.entry_valid),
    .out_last        (out_ch.last)
  );

endmodule

// ----- dv/top_k_score_keeper_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_score_keeper_tb
// Drives insert, read-out, clear and idle commands into the top-k store under
// several keep_count settings and random source/sink stalls. A local model of
// the sorted store predicts every read-out, and each result transfer is
// checked field by field against it.
// ----------------------------------------------------------------------------
module top_k_score_keeper_tb;
  import tksk_pkg::*;

  localparam int SCORE_W       = 32;
  localparam int MAX_KEPT      = 16;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 38;
  localparam int NUM_PHASES    = 12;

  typedef struct {
    mode_t                     mode;
    logic signed [SCORE_W-1:0] score;
    logic [POS_W-1:0]          position;
    logic [TAG_W-1:0]          tag;
  } score_cmd_t;

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic [POS_W-1:0]          position;
    logic [TAG_W-1:0]          tag;
    logic                      entry_valid;
    logic                      last;
  } ranked_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tksk_in_if  #(.SCORE_WIDTH(SCORE_W)) in_ch ();
  tksk_out_if #(.SCORE_WIDTH(SCORE_W)) out_ch ();

  top_k_score_keeper #(
    .MAX_ENTRIES (MAX_KEPT),
    .SCORE_WIDTH (SCORE_W)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // local copy of the sorted store, ascending score, ties in arrival order
  logic signed [SCORE_W-1:0] kept_score [MAX_KEPT];
  logic [POS_W-1:0]          kept_pos   [MAX_KEPT];
  logic [TAG_W-1:0]          kept_tag   [MAX_KEPT];
  int                        kept_count = 0;
  logic [KEEP_W-1:0]         keep_reg   = KEEP_RESET;

  score_cmd_t    pending_cmds [$];
  ranked_entry_t expected_readout [$];
  score_cmd_t    on_bus;

  int issued_count   = 0;
  int accepted_count = 0;
  int fail_count     = 0;
  int cycle_count    = 0;
  int send_gap       = 0;
  int recv_stall     = 0;
  int send_gap_max   = 0;
  int recv_stall_max = 0;

  logic [KEEP_W-1:0] keep_plan [NUM_PHASES] = '{
    5'd16, 5'd3, 5'd31, 5'd1, 5'd8, 5'd0, 5'd2, 5'd17, 5'd16, 5'd4, 5'd15, 5'd16
  };

  function automatic int effective_limit();
    if (keep_reg == 0) return 1;
    if (keep_reg > MAX_KEPT) return MAX_KEPT;
    return int'(keep_reg);
  endfunction

  function automatic void store_entry(input score_cmd_t c);
    int slot;
    slot = 0;
    if (kept_count >= effective_limit()) begin
      // full: only a score above the current minimum gets in
      if (kept_count == 0 || c.score <= kept_score[0]) return;
      for (int i = 1; i < kept_count; i++) begin
        kept_score[i-1] = kept_score[i];
        kept_pos[i-1]   = kept_pos[i];
        kept_tag[i-1]   = kept_tag[i];
      end
      kept_count--;
    end
    if (kept_count >= MAX_KEPT) return;
    while (slot < kept_count && kept_score[slot] <= c.score) slot++;
    for (int i = kept_count; i > slot; i--) begin
      kept_score[i] = kept_score[i-1];
      kept_pos[i]   = kept_pos[i-1];
      kept_tag[i]   = kept_tag[i-1];
    end
    kept_score[slot] = c.score;
    kept_pos[slot]   = c.position;
    kept_tag[slot]   = c.tag;
    kept_count++;
  endfunction

  function automatic void apply_command(input score_cmd_t c);
    ranked_entry_t e;
    case (c.mode)
      MODE_INSERT: store_entry(c);
      MODE_CLEAR:  kept_count = 0;
      MODE_READ: begin
        if (kept_count == 0) begin
          e = '{score: '0, position: '0, tag: '0, entry_valid: 1'b0, last: 1'b1};
          expected_readout.push_back(e);
        end else begin
          for (int i = 0; i < kept_count; i++) begin
            e = '{score: kept_score[i], position: kept_pos[i], tag: kept_tag[i],
                  entry_valid: 1'b1, last: (i == kept_count - 1)};
            expected_readout.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_command(on_bus);
        accepted_count++;
        send_gap = $urandom_range(0, send_gap_max);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          on_bus = pending_cmds.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.mode     <= on_bus.mode;
          in_ch.score    <= on_bus.score;
          in_ch.position <= on_bus.position;
          in_ch.tag      <= on_bus.tag;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and sink stalls
  always @(posedge clk) begin
    ranked_entry_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_readout.size() == 0) begin
          $error("unexpected result transfer: out_score %0d out_tag %0d",
                 out_ch.out_score, out_ch.out_tag);
          fail_count++;
        end else begin
          want = expected_readout.pop_front();
          if (out_ch.out_score !== want.score) begin
            $error("out_score mismatch: expected %0d, got %0d", want.score, out_ch.out_score);
            fail_count++;
          end
          if (out_ch.out_position !== want.position) begin
            $error("out_position mismatch: expected %0d, got %0d",
                   want.position, out_ch.out_position);
            fail_count++;
          end
          if (out_ch.out_tag !== want.tag) begin
            $error("out_tag mismatch: expected %0d, got %0d", want.tag, out_ch.out_tag);
            fail_count++;
          end
          if (out_ch.entry_valid !== want.entry_valid) begin
            $error("entry_valid mismatch: expected %0d, got %0d",
                   want.entry_valid, out_ch.entry_valid);
            fail_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, out_ch.last);
            fail_count++;
          end
        end
        recv_stall = $urandom_range(0, recv_stall_max);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_cmd(input mode_t m, input logic signed [SCORE_W-1:0] s,
                           input logic [POS_W-1:0] p, input logic [TAG_W-1:0] t);
    score_cmd_t c;
    c = '{mode: m, score: s, position: p, tag: t};
    pending_cmds.push_back(c);
    issued_count++;
  endtask

  task automatic queue_random_cmd();
    int unsigned pick;
    logic signed [SCORE_W-1:0] s;
    mode_t m;
    pick = $urandom_range(0, 99);
    if (pick < 72)      m = MODE_INSERT;
    else if (pick < 88) m = MODE_READ;
    else if (pick < 94) m = MODE_CLEAR;
    else                m = MODE_NOP;
    case ($urandom_range(0, 3))
      0: s = SCORE_W'($urandom);
      // narrow integer grid gives many equal scores
      1: s = (SCORE_W'(signed'($urandom_range(0, 8))) - 4) <<< 16;
      2: begin
        case ($urandom_range(0, 3))
          0: s = 32'sh8000_0000;
          1: s = 32'sh7FFF_FFFF;
          2: s = '0;
          default: s = -1;
        endcase
      end
      default: s = SCORE_W'(signed'($urandom_range(0, 200))) - 100;
    endcase
    queue_cmd(m, s, POS_W'($urandom), TAG_W'($urandom));
  endtask

  // blocks until every command is taken and every read-out has come back
  task automatic wait_for_drain();
    while (accepted_count != issued_count || expected_readout.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep_count(input logic [KEEP_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {KEEP_COUNT_IDX, 2'b00};
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    keep_reg = v;
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_NOP;
    in_ch.score    = '0;
    in_ch.position = '0;
    in_ch.tag      = '0;
    out_ch.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty read-out, score extremes, ties, idle command, clear
    send_gap_max   = 2;
    recv_stall_max = 2;
    queue_cmd(MODE_READ,   '0, '0, '0);
    queue_cmd(MODE_INSERT, 32'sh8000_0000, '0, '0);
    queue_cmd(MODE_INSERT, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_cmd(MODE_INSERT, '0, 31'h2AAA_AAAA, 31'h5555_5555);
    queue_cmd(MODE_INSERT, -1, 31'h5555_5555, 31'h2AAA_AAAA);
    queue_cmd(MODE_INSERT, 32'sh0001_0000, 31'd100, 31'd1);
    queue_cmd(MODE_INSERT, 32'sh0001_0000, 31'd101, 31'd2);
    queue_cmd(MODE_NOP,    32'sh1234_5678, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_cmd(MODE_READ,   '0, '0, '0);
    queue_cmd(MODE_CLEAR,  '0, '0, '0);
    queue_cmd(MODE_READ,   '0, '0, '0);
    wait_for_drain();

    // single slot: equal and lower scores dropped, higher evicts
    write_keep_count(5'd1);
    queue_cmd(MODE_INSERT, 32'sh0005_0000, 31'd1, 31'd10);
    queue_cmd(MODE_INSERT, 32'sh0005_0000, 31'd2, 31'd11);
    queue_cmd(MODE_INSERT, 32'sh0003_0000, 31'd3, 31'd12);
    queue_cmd(MODE_INSERT, 32'sh0006_0000, 31'd4, 31'd13);
    queue_cmd(MODE_READ,   '0, '0, '0);
    wait_for_drain();

    // zero limit behaves as one
    write_keep_count(5'd0);
    queue_cmd(MODE_INSERT, 32'sh0007_0000, 31'd5, 31'd14);
    queue_cmd(MODE_INSERT, 32'sh0007_0000, 31'd6, 31'd15);
    queue_cmd(MODE_READ,   '0, '0, '0);
    wait_for_drain();

    // random phases, no clear between them so a lowered limit meets a fuller store
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_keep_count(ph == 10 ? KEEP_W'($urandom_range(1, MAX_KEPT)) : keep_plan[ph]);
      case (ph % 4)
        0: begin send_gap_max = 0;  recv_stall_max = 0;  end
        1: begin send_gap_max = 16; recv_stall_max = 16; end
        2: begin send_gap_max = 16; recv_stall_max = 0;  end
        default: begin send_gap_max = 0; recv_stall_max = 16; end
      endcase
      repeat (PHASE_ITEMS) queue_random_cmd();
      queue_cmd(MODE_READ, '0, '0, '0);
      wait_for_drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/tksk_pkg.sv
src/tksk_if.sv
src/tksk_ctrl.sv
src/tksk_dp.sv
src/top_k_score_keeper.sv
dv/top_k_score_keeper_tb.sv
